@@ design/naa_pkg.sv @@
package naa_pkg;

    typedef struct packed {
        logic [31:0] own_activity;
        logic [23:0] nbr_distance;
        logic [31:0] nbr_activity;
        logic        no_neighbours;
        logic        last_neighbour;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  metric;
        logic [31:0] value;
        logic [31:0] diff;
        logic        value_valid;
        logic        query_last;
    } out_item_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_K_NEAREST  = 3'd0;
    localparam logic [2:0] REG_K_WEIGHTED = 3'd1;
    localparam logic [2:0] REG_RAMP_LOW   = 3'd2;
    localparam logic [2:0] REG_RAMP_HIGH  = 3'd3;
    localparam logic [2:0] REG_RAMP_INV   = 3'd4;
    localparam logic [2:0] REG_DIST_LIMIT = 3'd5;
    localparam logic [2:0] REG_DIFF_EN    = 3'd6;

    localparam logic [2:0] METRIC_DIST     = 3'd0;
    localparam logic [2:0] METRIC_KNN      = 3'd1;
    localparam logic [2:0] METRIC_CLOSEST  = 3'd2;
    localparam logic [2:0] METRIC_RAMP     = 3'd3;
    localparam logic [2:0] METRIC_WEIGHTED = 3'd4;

    // Neighbours beyond this count in one query are ignored.
    localparam logic [12:0] MAX_NEIGHBOURS = 13'd256;

    // Totals of one finished query, passed from front to back.
    typedef struct packed {
        logic        any;
        logic [31:0] query;
        logic [23:0] first_distance;
        logic [31:0] first_activity;
        logic [40:0] knn_sum;
        logic [8:0]  knn_count;
        logic [31:0] closest;
        logic [63:0] ramp_total;
        logic [47:0] ramp_wsum;
        logic [63:0] wt_total;
        logic [47:0] wt_wsum;
    } summary_t;

endpackage

@@ design/neighbour_activity_aggregator.sv @@
// The accumulating front end takes no new neighbour transaction while the last is in stage one.
// With the back end idle, the first result passes stage one, the queue and the back end's idle
// and send states into the output register after the last neighbour is accepted; metrics one,
// three and four also wait in the one-bit-a-cycle divider whenever a divide runs for them.
// The next query's neighbours accumulate meanwhile; a two-entry queue parts the two.
// Reset clears all control state and restores the register reset values.
module neighbour_activity_aggregator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  naa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output naa_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [8:0]  kn_reg, kw_reg;
    logic [23:0] rl_reg, rh_reg, dl_reg;
    logic [31:0] ri_reg;
    logic        de_reg;
    logic        sv, sf, qv, qt;
    naa_pkg::summary_t sd, qd;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kn_reg <= 9'd5; kw_reg <= 9'd5; rl_reg <= '0; rh_reg <= 24'd65536;
            ri_reg <= 32'd65536; dl_reg <= '0; de_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                naa_pkg::REG_K_NEAREST:  kn_reg <= cfg_data[8:0];
                naa_pkg::REG_K_WEIGHTED: kw_reg <= cfg_data[8:0];
                naa_pkg::REG_RAMP_LOW:   rl_reg <= cfg_data[23:0];
                naa_pkg::REG_RAMP_HIGH:  rh_reg <= cfg_data[23:0];
                naa_pkg::REG_RAMP_INV:   ri_reg <= cfg_data;
                naa_pkg::REG_DIST_LIMIT: dl_reg <= cfg_data[23:0];
                naa_pkg::REG_DIFF_EN:    de_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    naa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .k_nearest(kn_reg), .k_weighted(kw_reg),
        .ramp_low(rl_reg), .ramp_high(rh_reg), .ramp_inverse_span(ri_reg),
        .distance_limit(dl_reg), .sum_valid(sv), .sum_full(sf), .sum_data(sd)
    );

    naa_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(sv), .full(sf), .wr_data(sd),
        .rd_valid(qv), .rd_take(qt), .rd_data(qd)
    );

    naa_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_take(qt), .q_data(qd),
        .diff_enable(de_reg), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

endmodule

@@ design/naa_front.sv @@
module naa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  naa_pkg::in_item_t   in_data,
    input  logic [8:0]          k_nearest,
    input  logic [8:0]          k_weighted,
    input  logic [23:0]         ramp_low,
    input  logic [23:0]         ramp_high,
    input  logic [31:0]         ramp_inverse_span,
    input  logic [23:0]         distance_limit,
    output logic                sum_valid,
    input  logic                sum_full,
    output naa_pkg::summary_t   sum_data
);

    // Stage one registers the item and its ramp product; stage two accumulates.
    logic             s1_reg;
    naa_pkg::in_item_t it_reg;
    logic [55:0]      frac_prod_reg;
    logic             le_low_reg, ge_high_reg;

    logic [12:0] count_reg, count_next;
    logic [31:0] query_reg, query_next;
    logic [23:0] fd_reg, fd_next;
    logic [31:0] fa_reg, fa_next;
    logic [40:0] knn_reg, knn_next;
    logic [31:0] cl_reg, cl_next;
    logic [32:0] gap_reg, gap_next;
    logic [63:0] rt_reg, rt_next;
    logic [47:0] rw_reg, rw_next;
    logic        rs_reg, rs_next;
    logic [63:0] wt_reg, wt_next;
    logic [47:0] ww_reg, ww_next;
    logic        tr_reg, tr_next;
    logic        emit;
    naa_pkg::summary_t sum_c;

    // A new item waits while the last one is in stage one; every item waits while the queue is full.
    assign in_stall = s1_reg || sum_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= in_valid && !in_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            it_reg        <= in_data;
            frac_prod_reg <= 56'({8'd0, in_data.nbr_distance - ramp_low})
                             * 56'(ramp_inverse_span);
            le_low_reg    <= in_data.nbr_distance <= ramp_low;
            ge_high_reg   <= in_data.nbr_distance >= ramp_high;
        end
    end

    logic [8:0] kn, kw;
    assign kn = (k_nearest == 9'd0) ? 9'd1 : k_nearest;
    assign kw = (k_weighted == 9'd0) ? 9'd1 : k_weighted;

    always_comb
    begin
        logic signed [32:0] g;
        logic [32:0]        gap;
        logic [47:0]        frac;
        logic signed [17:0] w_r;
        logic signed [25:0] w_w;
        logic signed [63:0] prod_r, prod_w, s;
        logic               trunc, acc;
        count_next = count_reg; query_next = query_reg; fd_next = fd_reg;
        fa_next = fa_reg; knn_next = knn_reg; cl_next = cl_reg; gap_next = gap_reg;
        rt_next = rt_reg; rw_next = rw_reg; rs_next = rs_reg; wt_next = wt_reg;
        ww_next = ww_reg; tr_next = tr_reg; emit = 1'b0;
        g = '0; gap = '0; frac = '0; w_r = '0; w_w = '0; prod_r = '0; prod_w = '0;
        s = '0; trunc = 1'b0; acc = 1'b0;
        if (s1_reg)
        begin
            if (it_reg.no_neighbours)
            begin
                count_next = '0; tr_next = 1'b0;
                emit = 1'b1;
            end
            else
            begin
                if (count_reg == 13'd0 && !tr_reg)
                begin
                    query_next = it_reg.own_activity;
                end
                trunc = tr_reg || (distance_limit != 24'd0
                                   && it_reg.nbr_distance > distance_limit);
                tr_next = trunc;
                acc = !trunc && count_reg < naa_pkg::MAX_NEIGHBOURS;
                if (acc)
                begin
                    if (count_reg == 13'd0)
                    begin
                        fd_next = it_reg.nbr_distance;
                        fa_next = it_reg.nbr_activity;
                    end
                    if (count_reg < {4'd0, kn})
                    begin
                        g = $signed({query_next[31], query_next})
                            - $signed({it_reg.nbr_activity[31], it_reg.nbr_activity});
                        gap = g[32] ? 33'(-g) : 33'(g);
                        knn_next = knn_reg + {{9{it_reg.nbr_activity[31]}}, it_reg.nbr_activity};
                        if (gap < gap_reg)
                        begin
                            gap_next = gap;
                            cl_next = it_reg.nbr_activity;
                        end
                    end
                    if (!rs_reg)
                    begin
                        frac = {8'd0, frac_prod_reg[55:16]};
                        if (le_low_reg)
                        begin
                            w_r = 18'sd65536;
                        end
                        else if (ge_high_reg)
                        begin
                            rs_next = 1'b1;
                        end
                        else
                        begin
                            w_r = (frac >= 48'd65536) ? 18'sd0 : 18'(65536 - frac[16:0]);
                        end
                        prod_r = 64'($signed(it_reg.nbr_activity)) * 64'(w_r);
                        rt_next = rt_reg + prod_r;
                        rw_next = rw_reg + {{30{w_r[17]}}, w_r};
                    end
                    if (count_reg < {4'd0, kw})
                    begin
                        // One minus distance; goes negative beyond a distance of one.
                        w_w = 26'sd65536 - $signed({2'b00, it_reg.nbr_distance});
                        prod_w = 64'($signed(it_reg.nbr_activity)) * 64'(w_w);
                        s = wt_reg + prod_w;
                        if (!wt_reg[63] && !prod_w[63] && s[63])
                        begin
                            s = 64'h7FFF_FFFF_FFFF_FFFF;
                        end
                        else if (wt_reg[63] && prod_w[63] && !s[63])
                        begin
                            s = 64'h8000_0000_0000_0000;
                        end
                        wt_next = s;
                        ww_next = ww_reg + {{22{w_w[25]}}, w_w};
                    end
                    count_next = count_reg + 13'd1;
                end
                emit = it_reg.last_neighbour;
            end
        end
        sum_c.any = !it_reg.no_neighbours && count_next != 13'd0;
        sum_c.query = it_reg.no_neighbours ? 32'd0 : query_next;
        sum_c.first_distance = fd_next;
        sum_c.first_activity = fa_next;
        sum_c.knn_sum = knn_next;
        sum_c.knn_count = (count_next < {4'd0, kn}) ? count_next[8:0] : kn;
        sum_c.closest = cl_next;
        sum_c.ramp_total = rt_next;
        sum_c.ramp_wsum = rw_next;
        sum_c.wt_total = wt_next;
        sum_c.wt_wsum = ww_next;
    end

    // Accumulators; they return to their reset values once a query is emitted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0; query_reg <= '0; fd_reg <= '0; fa_reg <= '0;
            knn_reg <= '0; cl_reg <= '0; gap_reg <= '1; rt_reg <= '0; rw_reg <= '0;
            rs_reg <= 1'b0; wt_reg <= '0; ww_reg <= '0; tr_reg <= 1'b0;
        end
        else if (emit)
        begin
            count_reg <= '0; query_reg <= '0; fd_reg <= '0; fa_reg <= '0;
            knn_reg <= '0; cl_reg <= '0; gap_reg <= '1; rt_reg <= '0; rw_reg <= '0;
            rs_reg <= 1'b0; wt_reg <= '0; ww_reg <= '0; tr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next; query_reg <= query_next; fd_reg <= fd_next;
            fa_reg <= fa_next; knn_reg <= knn_next; cl_reg <= cl_next;
            gap_reg <= gap_next; rt_reg <= rt_next; rw_reg <= rw_next;
            rs_reg <= rs_next; wt_reg <= wt_next; ww_reg <= ww_next;
            tr_reg <= tr_next;
        end
    end

    assign sum_valid = emit;
    assign sum_data  = sum_c;

endmodule

@@ design/naa_queue.sv @@
module naa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              full,
    input  naa_pkg::summary_t wr_data,
    output logic              rd_valid,
    input  logic              rd_take,
    output naa_pkg::summary_t rd_data
);

    // Two-entry queue of query summaries.
    naa_pkg::summary_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid) wp_reg <= !wp_reg;
            if (rd_take)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid) - 2'(rd_take);
        end
    end

endmodule

@@ design/naa_divider.sv @@
module naa_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [47:0] den,
    output logic        done,
    output logic [31:0] quot
);

    // Restoring division on magnitudes, one quotient bit a cycle.
    logic [63:0] q_reg;
    logic [63:0] rem_reg;
    logic [47:0] d_reg;
    logic        neg_reg, busy_reg, done_reg;
    logic [5:0]  bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; bit_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1; bit_reg <= 6'd63;
            end
            else if (busy_reg)
            begin
                if (bit_reg == 6'd0)
                begin
                    busy_reg <= 1'b0; done_reg <= 1'b1;
                end
                bit_reg <= bit_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [64:0] r;
        r = '0;
        if (start)
        begin
            q_reg   <= num[63] ? 64'(-num) : num;
            d_reg   <= den[47] ? 48'(-den) : den;
            neg_reg <= num[63] != den[47];
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            r = {rem_reg, q_reg[63]};
            if (r >= {17'd0, d_reg})
            begin
                r = r - {17'd0, d_reg};
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[62:0], 1'b0};
            end
            rem_reg <= r[63:0];
        end
    end

    assign done = done_reg;
    always_comb
    begin
        if (neg_reg)
        begin
            quot = (q_reg >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q_reg);
        end
        else
        begin
            quot = (q_reg >= 64'h8000_0000) ? 32'h7FFF_FFFF : q_reg[31:0];
        end
    end

endmodule

@@ design/naa_back.sv @@
module naa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_take,
    input  naa_pkg::summary_t  q_data,
    input  logic               diff_enable,
    output logic               out_valid,
    input  logic               out_stall,
    output naa_pkg::out_item_t out_data
);

    typedef enum logic [1:0] {S_IDLE, S_WAIT, S_SEND} state_t;

    state_t      state_reg;
    logic [2:0]  met_reg;
    logic [31:0] res_reg;
    logic        ok_reg;
    logic        ov_reg;
    naa_pkg::out_item_t od_reg;
    logic        dstart;
    logic        ddone;
    logic [31:0] dq;
    logic [63:0] dnum;
    logic [47:0] dden;
    logic        need_div;
    logic        div_ok;
    logic        send_fire;

    // Choose the operands for the current metric.
    always_comb
    begin
        dnum = '0; dden = '0; need_div = 1'b0; div_ok = q_data.any;
        case (met_reg)
            naa_pkg::METRIC_KNN:
            begin
                dnum = {{23{q_data.knn_sum[40]}}, q_data.knn_sum};
                dden = {39'd0, q_data.knn_count};
                need_div = q_data.any;
            end
            naa_pkg::METRIC_RAMP:
            begin
                dnum = q_data.ramp_total; dden = q_data.ramp_wsum;
                div_ok = q_data.any && q_data.ramp_wsum != '0;
                need_div = div_ok;
            end
            naa_pkg::METRIC_WEIGHTED:
            begin
                dnum = q_data.wt_total; dden = q_data.wt_wsum;
                div_ok = q_data.any && q_data.wt_wsum != '0;
                need_div = div_ok;
            end
            default: ;
        endcase
    end

    naa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (dden),
        .done  (ddone),
        .quot  (dq)
    );

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) - $signed({b[31], b});
        if (s > 33'sd2147483647) return 32'h7FFF_FFFF;
        if (s < -33'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    // A result moves into the output register when that register is free or draining.
    assign send_fire = state_reg == S_SEND && (!ov_reg || !out_stall);
    assign dstart = state_reg == S_IDLE && q_valid && need_div;
    assign q_take = send_fire && met_reg == naa_pkg::METRIC_WEIGHTED;

    // One result per metric; metrics one, three and four divide if the query has neighbours and a nonzero divisor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; met_reg <= naa_pkg::METRIC_DIST; ov_reg <= 1'b0;
            res_reg <= '0; ok_reg <= 1'b0; od_reg <= '0;
        end
        else
        begin
            if (send_fire) ov_reg <= 1'b1;
            else if (ov_reg && !out_stall) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ok_reg <= div_ok;
                        if (need_div)
                        begin
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            res_reg <= (met_reg == naa_pkg::METRIC_DIST)
                                ? {8'd0, q_data.first_distance} : q_data.closest;
                            state_reg <= S_SEND;
                        end
                    end
                end
                S_WAIT:
                begin
                    if (ddone)
                    begin
                        res_reg <= dq; state_reg <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    if (send_fire)
                    begin
                        od_reg.metric <= met_reg;
                        od_reg.value <= ok_reg ? res_reg : 32'd0;
                        od_reg.diff <= (ok_reg && diff_enable) ? sat_sub(
                            (met_reg == naa_pkg::METRIC_DIST) ? q_data.first_activity
                                                              : res_reg,
                            q_data.query) : 32'd0;
                        od_reg.value_valid <= ok_reg;
                        od_reg.query_last <= met_reg == naa_pkg::METRIC_WEIGHTED;
                        met_reg <= (met_reg == naa_pkg::METRIC_WEIGHTED)
                            ? naa_pkg::METRIC_DIST : met_reg + 3'd1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

@@ design/naa_checker.sv @@
module naa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input naa_pkg::out_item_t out_data
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // The last flag marks metric four only.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.query_last == (out_data.metric == naa_pkg::METRIC_WEIGHTED))
        else $error("last flag wrong");

    // An invalid result carries zero value and diff.
    a_inv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.value_valid |-> out_data.value == '0 && out_data.diff == '0)
        else $error("invalid result not zero");

endmodule

bind neighbour_activity_aggregator naa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
);
